// ===== rtl/rlcq_pkg.sv =====
package rlcq_pkg;

  localparam int unsigned Slots     = 16;
  localparam int unsigned SlotBytes = 16;

  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned ByteIdxW  = (SlotBytes > 1) ? $clog2(SlotBytes) : 1;
  localparam int unsigned LenW      = $clog2(SlotBytes + 2);
  localparam int unsigned MemDepth  = Slots * SlotBytes;
  localparam int unsigned MemAw     = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned QcW       = 4;
  localparam int unsigned QcMax     = 15;

  localparam logic [ElapsedW-1:0] ElapsedMax    = 16'hFFFF;
  localparam logic [ElapsedW-1:0] IntervalReset = 16'd5000;

  typedef enum logic [1:0] {
    KIND_SENT       = 2'd0,
    KIND_QUEUED     = 2'd1,
    KIND_DROP_FULL  = 2'd2,
    KIND_DROP_LONG  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [SlotW-1:0]    slot;
    logic [LenW-1:0]     len;
    logic [QcW-1:0]      qcount;
  } job_t;

  typedef struct packed {
    logic               en;
    logic [MemAw-1:0]   addr;
    logic [7:0]         data;
  } mem_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic send_pending;
  } jobq_status_t;

  function automatic logic [MemAw-1:0] mem_addr(input logic [SlotW-1:0] slot,
                                                 input logic [ByteIdxW-1:0] idx);
    return MemAw'(slot) * MemAw'(SlotBytes) + MemAw'(idx);
  endfunction

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
    return (s == SlotW'(Slots - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [QcW-1:0] ring_count(input logic [SlotW-1:0] head,
                                                 input logic [SlotW-1:0] tail);
    logic [SlotW:0] diff;
    if (tail >= head) begin
      diff = {1'b0, tail} - {1'b0, head};
    end else begin
      diff = {1'b0, tail} + (SlotW+1)'(Slots) - {1'b0, head};
    end
    return (diff > QcMax) ? QcW'(QcMax) : QcW'(diff);
  endfunction

endpackage

// ===== rtl/rlcq_front.sv =====
module rlcq_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [15:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_func_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      in_last_i,
  input  rlcq_pkg::jobq_status_t    jobq_status_i,
  output logic                      push_o,
  output rlcq_pkg::job_t            job_o,
  output rlcq_pkg::mem_wr_t         mem_wr_o
);
  import rlcq_pkg::*;

  logic [SlotW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [LenW-1:0]     staged_q, staged_d, staged_inc;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d, el_inc;
  logic [ElapsedW-1:0] min_q;
  logic [LenW-1:0]     lengths_q [Slots];
  logic                len_we;
  logic                accept, ring_empty, too_long;

  assign in_ready_o = !jobq_status_i.full && !jobq_status_i.send_pending;
  assign accept     = in_valid_i && in_ready_o;
  assign ring_empty = (head_q == tail_q);
  assign el_inc     = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
  assign staged_inc = (staged_q <= LenW'(SlotBytes)) ? staged_q + 1'b1 : staged_q;
  assign too_long   = (staged_inc > LenW'(SlotBytes));

  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    staged_d      = staged_q;
    elapsed_d     = elapsed_q;
    push_o        = 1'b0;
    len_we        = 1'b0;
    job_o.kind    = KIND_SENT;
    job_o.slot    = tail_q;
    job_o.len     = staged_inc;
    job_o.qcount  = ring_count(head_q, tail_q);
    mem_wr_o.en   = 1'b0;
    mem_wr_o.addr = mem_addr(tail_q, staged_q[ByteIdxW-1:0]);
    mem_wr_o.data = in_byte_i;
    if (accept) begin
      if (!in_func_i) begin
        elapsed_d = el_inc;
        if (!ring_empty && (el_inc >= min_q)) begin
          push_o       = 1'b1;
          job_o.slot   = head_q;
          job_o.len    = lengths_q[head_q];
          job_o.qcount = ring_count(slot_inc(head_q), tail_q);
          head_d       = slot_inc(head_q);
          elapsed_d    = '0;
        end
      end else begin
        mem_wr_o.en = (staged_q < LenW'(SlotBytes));
        staged_d    = staged_inc;
        if (in_last_i) begin
          staged_d = '0;
          push_o   = 1'b1;
          if (!too_long && ring_empty && (elapsed_q >= min_q)) begin
            elapsed_d = '0;
          end else if (slot_inc(tail_q) == head_q) begin
            job_o.kind = KIND_DROP_FULL;
          end else if (too_long) begin
            job_o.kind = KIND_DROP_LONG;
          end else begin
            job_o.kind   = KIND_QUEUED;
            job_o.qcount = ring_count(head_q, slot_inc(tail_q));
            len_we       = 1'b1;
            tail_d       = slot_inc(tail_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      staged_q  <= '0;
      elapsed_q <= '0;
      min_q     <= IntervalReset;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      staged_q  <= staged_d;
      elapsed_q <= elapsed_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      lengths_q[tail_q] <= staged_inc;
    end
  end

endmodule

// ===== rtl/rlcq_jobq.sv =====
module rlcq_jobq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  rlcq_pkg::job_t            job_i,
  input  logic                      pop_i,
  output rlcq_pkg::job_t            job_o,
  output rlcq_pkg::jobq_status_t    status_o
);
  import rlcq_pkg::*;

  job_t       entries_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q;
  logic [1:0] valid;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      valid[i] = (cnt_q == 2'd2) || ((cnt_q == 2'd1) && (rd_ptr_q == 1'(i)));
    end
  end

  assign job_o                 = entries_q[rd_ptr_q];
  assign status_o.empty        = (cnt_q == 2'd0);
  assign status_o.full         = (cnt_q == 2'd2);
  assign status_o.send_pending = (valid[0] && entries_q[0].kind == KIND_SENT) ||
                                 (valid[1] && entries_q[1].kind == KIND_SENT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/rlcq_back.sv =====
module rlcq_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rlcq_pkg::mem_wr_t         mem_wr_i,
  input  logic                      job_valid_i,
  input  rlcq_pkg::job_t            job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rlcq_pkg::kind_e           out_kind_o,
  output logic [7:0]                out_byte_o,
  output logic                      out_last_o,
  output logic [rlcq_pkg::QcW-1:0]  out_qcount_o
);
  import rlcq_pkg::*;

  logic [7:0]          mem_q [MemDepth];
  logic [ByteIdxW-1:0] idx_q;
  logic                rd_valid_q, rd_last_q;
  kind_e               rd_kind_q;
  logic [QcW-1:0]      rd_qc_q;
  logic [7:0]          rd_byte_q;
  logic                out_valid_q, out_last_q;
  kind_e               out_kind_q;
  logic [7:0]          out_byte_q;
  logic [QcW-1:0]      out_qc_q;
  logic                out_free, rd_free, issue, is_send, last_byte;

  assign out_free  = !out_valid_q || out_ready_i;
  assign rd_free   = !rd_valid_q || out_free;
  assign issue     = job_valid_i && rd_free;
  assign is_send   = (job_i.kind == KIND_SENT);
  assign last_byte = ((LenW'(idx_q) + 1'b1) == job_i.len);
  assign pop_o     = issue && (!is_send || last_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue && is_send) begin
        idx_q <= last_byte ? '0 : idx_q + 1'b1;
      end
      if (rd_free) begin
        rd_valid_q <= issue;
      end
      if (out_free) begin
        out_valid_q <= rd_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[mem_wr_i.addr] <= mem_wr_i.data;
    end
    if (issue && is_send) begin
      rd_byte_q <= mem_q[mem_addr(job_i.slot, idx_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_kind_q <= job_i.kind;
      rd_last_q <= !is_send || last_byte;
      rd_qc_q   <= job_i.qcount;
    end
    if (out_free && rd_valid_q) begin
      out_kind_q <= rd_kind_q;
      out_byte_q <= (rd_kind_q == KIND_SENT) ? rd_byte_q : 8'd0;
      out_last_q <= rd_last_q;
      out_qc_q   <= rd_qc_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_qcount_o = out_qc_q;

endmodule

// ===== rtl/rate_limited_command_queue.sv =====
// Channel   Direction  tdata                            tuser          tlast
// s_axis    in         [7:0] cmd_byte                   [0] func       cmd_last
// m_axis    out        [7:0] out_byte, [11:8] queued    [1:0] out_kind out_last
// cfg       in         cfg_wdata_i = min_interval_ticks, written when cfg_we_i
//
// One input transfer per cycle while no send is in flight.
// A send streams its N stored bytes one per cycle, unless m_axis stalls, through the
// single byte-memory read port; input stalls from the send decision to its last read.
// The two-entry job queue and the output register stall the front when full.
// Reset clears ring pointers, staged count and elapsed ticks; interval returns to 5000.
module rate_limited_command_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
  input  logic        s_axis_tuser,   // [0] func
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] queued_count, [15:12] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast
);
  import rlcq_pkg::*;

  logic         push, pop;
  job_t         push_job, head_job;
  mem_wr_t      mem_wr;
  jobq_status_t jobq_status;
  kind_e        out_kind;
  logic [7:0]   out_byte;
  logic [QcW-1:0] out_qcount;

  rlcq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_func_i     (s_axis_tuser),
    .in_byte_i     (s_axis_tdata),
    .in_last_i     (s_axis_tlast),
    .jobq_status_i (jobq_status),
    .push_o        (push),
    .job_o         (push_job),
    .mem_wr_o      (mem_wr)
  );

  rlcq_jobq u_jobq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (jobq_status)
  );

  rlcq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mem_wr_i     (mem_wr),
    .job_valid_i  (!jobq_status.empty),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (out_kind),
    .out_byte_o   (out_byte),
    .out_last_o   (m_axis_tlast),
    .out_qcount_o (out_qcount)
  );

  assign m_axis_tdata = {4'b0000, out_qcount, out_byte};
  assign m_axis_tuser = out_kind;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !jobq_status.full)
    else $error("job queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !jobq_status.empty)
    else $error("job queue underflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_SENT) |-> m_axis_tlast)
    else $error("status result without tlast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr.en |-> !jobq_status.send_pending)
    else $error("byte memory written during send");

endmodule
